// ===== src/iprup_pkg.sv =====
package iprup_pkg;

  // Default geometry of the source frame and the scale limit
  localparam int unsigned SrcWidthDefault  = 320;
  localparam int unsigned SrcHeightDefault = 200;
  localparam int unsigned MaxScaleDefault  = 8;

  // Largest scale that any configuration of the block may use
  localparam int unsigned MaxScaleLimit = 8;

  // Field and internal widths
  localparam int unsigned COL_W   = 9;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned SCALE_W = $clog2(MaxScaleLimit + 1);
  // Signed destination coordinates, wide enough for any source size and scale
  localparam int unsigned CRD_W   = 20;
  localparam int unsigned PROD_W  = 2 * DIM_W;

  localparam logic [PIX_W-1:0] OPAQUE_ALPHA = 32'hFF00_0000;

  // Register reset values
  localparam logic [DIM_W-1:0] DEST_WIDTH_RST  = 13'd320;
  localparam logic [DIM_W-1:0] DEST_HEIGHT_RST = 13'd200;
  localparam logic [DIM_W-1:0] ROW_PITCH_RST   = 13'd320;

  typedef enum logic [1:0] {
    CFG_DEST_WIDTH,
    CFG_DEST_HEIGHT,
    CFG_ROW_PITCH,
    CFG_FORCE_OPAQUE
  } cfg_idx_e;

  typedef struct packed {
    logic [COL_W-1:0] src_col;
    logic [ROW_W-1:0] src_row;
    logic [PIX_W-1:0] pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_data;
    logic              last_write;
  } out_item_t;

  // Settings and derived placement shared by the front and back ends
  typedef struct packed {
    logic [SCALE_W-1:0]      scale;
    logic signed [CRD_W-1:0] ox;
    logic signed [CRD_W-1:0] oy;
    logic [DIM_W-1:0]        dest_w;
    logic [DIM_W-1:0]        dest_h;
    logic [DIM_W-1:0]        pitch;
    logic                    opaque;
  } geom_t;

  // One clipped destination block, bounds inclusive
  typedef struct packed {
    logic [DIM_W-1:0] r_first;
    logic [DIM_W-1:0] r_last;
    logic [DIM_W-1:0] c_first;
    logic [DIM_W-1:0] c_last;
    logic [PIX_W-1:0] data;
  } job_t;

endpackage

// ===== src/iprup_geom.sv =====
module iprup_geom #(
  parameter int unsigned SRC_WIDTH  = iprup_pkg::SrcWidthDefault,
  parameter int unsigned SRC_HEIGHT = iprup_pkg::SrcHeightDefault,
  parameter int unsigned MAX_SCALE  = iprup_pkg::MaxScaleDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  iprup_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [iprup_pkg::DIM_W-1:0]   cfg_data_i,
  output iprup_pkg::geom_t              geom_o
);
  import iprup_pkg::*;

  logic [DIM_W-1:0] width_q, height_q, pitch_q;
  logic             opaque_q;

  logic [SCALE_W-1:0]      scale_d, scale_q;
  logic signed [CRD_W-1:0] ox_d, ox_q, oy_d, oy_q;
  logic [CRD_W-1:0]        span_w, span_h;
  logic signed [CRD_W-1:0] diff_w, diff_h;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DEST_WIDTH_RST;
      height_q <= DEST_HEIGHT_RST;
      pitch_q  <= ROW_PITCH_RST;
      opaque_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEST_WIDTH:   width_q  <= cfg_data_i;
        CFG_DEST_HEIGHT:  height_q <= cfg_data_i;
        CFG_ROW_PITCH:    pitch_q  <= cfg_data_i;
        CFG_FORCE_OPAQUE: opaque_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pick the largest scale whose image fits both ways, at least one
  always_comb begin
    scale_d = SCALE_W'(1);
    span_w  = CRD_W'(SRC_WIDTH);
    span_h  = CRD_W'(SRC_HEIGHT);
    for (int k = 2; k <= MAX_SCALE; k++) begin
      if (CRD_W'(width_q) >= CRD_W'(k * SRC_WIDTH) &&
          CRD_W'(height_q) >= CRD_W'(k * SRC_HEIGHT)) begin
        scale_d = SCALE_W'(k);
        span_w  = CRD_W'(k * SRC_WIDTH);
        span_h  = CRD_W'(k * SRC_HEIGHT);
      end
    end
  end

  // Center the image: halve the margin, rounding toward zero
  always_comb begin
    diff_w = $signed(CRD_W'(width_q)) - $signed(span_w);
    diff_h = $signed(CRD_W'(height_q)) - $signed(span_h);
    ox_d   = $signed(diff_w + $signed(CRD_W'(diff_w[CRD_W-1]))) >>> 1;
    oy_d   = $signed(diff_h + $signed(CRD_W'(diff_h[CRD_W-1]))) >>> 1;
  end

  // Refresh the placement every cycle
  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
  end

  assign geom_o = '{scale:  scale_q,
                    ox:     ox_q,
                    oy:     oy_q,
                    dest_w: width_q,
                    dest_h: height_q,
                    pitch:  pitch_q,
                    opaque: opaque_q};

endmodule

// ===== src/iprup_fifo.sv =====
module iprup_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic rd_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Store the incoming entry
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("queue read while empty");

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue level out of range");

endmodule

// ===== src/iprup_front.sv =====
module iprup_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  iprup_pkg::in_item_t in_item_i,
  input  iprup_pkg::geom_t    geom_i,
  output logic                job_wr_o,
  output iprup_pkg::job_t     job_o,
  input  logic                job_full_i
);
  import iprup_pkg::*;

  // Stage A: raw pixel
  logic     a_vld_q;
  in_item_t a_item_q;
  // Stage B: block origin and final color
  logic                    b_vld_q;
  logic signed [CRD_W-1:0] bx_q, by_q;
  logic [PIX_W-1:0]        data_q;

  logic                    acc, a_adv, b_rdy, b_keep;
  logic [CRD_W-1:0]        prod_x, prod_y;
  logic signed [CRD_W-1:0] bx_d, by_d, x_end, y_end, lim_w, lim_h;
  logic signed [CRD_W-1:0] c0, c1, r0, r1;

  // Drop blocks that land fully outside the destination
  assign b_rdy = !b_vld_q || !b_keep || !job_full_i;
  assign a_adv = a_vld_q && b_rdy;
  assign full  = a_vld_q && !b_rdy;
  assign acc   = push && !full;

  // Place the block origin
  always_comb begin
    prod_x = CRD_W'(a_item_q.src_col) * CRD_W'(geom_i.scale);
    prod_y = CRD_W'(a_item_q.src_row) * CRD_W'(geom_i.scale);
    bx_d   = geom_i.ox + $signed(prod_x);
    by_d   = geom_i.oy + $signed(prod_y);
  end

  // Clip the block to the destination
  always_comb begin
    x_end  = bx_q + $signed(CRD_W'(geom_i.scale));
    y_end  = by_q + $signed(CRD_W'(geom_i.scale));
    lim_w  = $signed(CRD_W'(geom_i.dest_w));
    lim_h  = $signed(CRD_W'(geom_i.dest_h));
    c0     = (bx_q < 0) ? '0 : bx_q;
    r0     = (by_q < 0) ? '0 : by_q;
    c1     = (x_end < lim_w) ? x_end : lim_w;
    r1     = (y_end < lim_h) ? y_end : lim_h;
    b_keep = (c0 < c1) && (r0 < r1);
  end

  assign job_wr_o      = b_vld_q && b_keep && !job_full_i;
  assign job_o.c_first = c0[DIM_W-1:0];
  assign job_o.c_last  = DIM_W'(c1 - CRD_W'(1));
  assign job_o.r_first = r0[DIM_W-1:0];
  assign job_o.r_last  = DIM_W'(r1 - CRD_W'(1));
  assign job_o.data    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= acc || (a_vld_q && !a_adv);
      b_vld_q <= a_adv || (b_vld_q && !b_rdy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_item_q <= in_item_i;
    end
    if (a_adv) begin
      bx_q   <= bx_d;
      by_q   <= by_d;
      data_q <= a_item_q.pixel_color | (geom_i.opaque ? OPAQUE_ALPHA : '0);
    end
  end

endmodule

// ===== src/iprup_back.sv =====
module iprup_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_empty_i,
  input  iprup_pkg::job_t      job_i,
  output logic                 job_rd_o,
  input  logic [iprup_pkg::DIM_W-1:0] pitch_i,
  output logic                 out_wr_o,
  output iprup_pkg::out_item_t out_item_o,
  input  logic                 out_full_i
);
  import iprup_pkg::*;

  // Walker over the current block
  logic             j_vld_q;
  job_t             j_q;
  logic [DIM_W-1:0] r_q, c_q;
  // Multiply stage
  logic              m_vld_q, m_last_q;
  logic [ADDR_W-1:0] m_prod_q;
  logic [DIM_W-1:0]  m_col_q;
  logic [PIX_W-1:0]  m_data_q;

  logic              m_rdy, issue, is_last, row_end, load;
  logic [PROD_W-1:0] prod;

  assign row_end  = (c_q == j_q.c_last);
  assign is_last  = row_end && (r_q == j_q.r_last);
  assign m_rdy    = !m_vld_q || !out_full_i;
  assign issue    = j_vld_q && m_rdy;
  assign load     = !job_empty_i && (!j_vld_q || (issue && is_last));
  assign job_rd_o = load;
  assign prod     = PROD_W'(r_q) * PROD_W'(pitch_i);
  assign out_wr_o = m_vld_q && !out_full_i;

  // Finish the address: row offset plus column, kept modulo the address space
  assign out_item_o = '{write_address: m_prod_q + ADDR_W'(m_col_q),
                        write_data:    m_data_q,
                        last_write:    m_last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      j_vld_q <= load || (j_vld_q && !(issue && is_last));
      m_vld_q <= issue || (m_vld_q && !out_wr_o);
    end
  end

  // Step across the block row by row
  always_ff @(posedge clk_i) begin
    if (load) begin
      j_q <= job_i;
      r_q <= job_i.r_first;
      c_q <= job_i.c_first;
    end else if (issue) begin
      if (row_end) begin
        c_q <= j_q.c_first;
        r_q <= r_q + 1'b1;
      end else begin
        c_q <= c_q + 1'b1;
      end
    end
    if (issue) begin
      m_prod_q <= prod[ADDR_W-1:0];
      m_col_q  <= c_q;
      m_data_q <= j_q.data;
      m_last_q <= is_last;
    end
  end

  a_walk_in_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_vld_q |-> (r_q <= j_q.r_last && c_q <= j_q.c_last && c_q >= j_q.c_first))
    else $error("walker left its block");

  a_new_block_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (r_q == j_q.r_first && c_q == j_q.c_first))
    else $error("block did not start at its corner");

  a_last_ends_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && is_last && job_empty_i) |=> !j_vld_q)
    else $error("walker kept going after the final write");

endmodule

// ===== src/integer_pixel_replicating_upscaler.sv =====
// Integer pixel-replicating upscaler.
// Input queue: present a source pixel (column, row, color) on in_item_i with push;
// it is taken at a clock edge where push is high and full is low.
// Output queue: while empty is low the oldest write (address, data, last flag)
// sits on out_item_o; pop takes it. last_write marks the final write of a pixel.
// Settings: cfg_we_i with cfg_idx_i and cfg_data_i writes one register: destination
// width, height, row pitch and opaque-alpha mode. Change them only while no
// pixel is in flight; the next cycle may push again.
// Each pixel becomes up to scale*scale writes (64 at the largest scale), one
// per cycle while the output queue has room, set by the back end's single
// address multiply-add path; a pixel whose block is fully clipped is dropped
// in the front end and produces nothing. Pixels whose blocks hold one visible
// write stream at one per cycle while the output queue has room.
// Reset brings width 320, height 200, pitch 320, opaque mode off, and empties
// every queue. When pop stays low the output queue fills, the back end holds,
// the block queue fills and then full rises; nothing is lost.
module integer_pixel_replicating_upscaler #(
  parameter int unsigned SRC_WIDTH  = iprup_pkg::SrcWidthDefault,
  parameter int unsigned SRC_HEIGHT = iprup_pkg::SrcHeightDefault,
  parameter int unsigned MAX_SCALE  = iprup_pkg::MaxScaleDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  iprup_pkg::in_item_t         in_item_i,
  output logic                        empty,
  input  logic                        pop,
  output iprup_pkg::out_item_t        out_item_o,
  input  logic                        cfg_we_i,
  input  iprup_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [iprup_pkg::DIM_W-1:0] cfg_data_i
);
  import iprup_pkg::*;

  geom_t     geom;
  logic      job_wr, job_full, job_rd, job_empty;
  job_t      job_in, job_out;
  logic      out_wr, out_full;
  out_item_t out_in;

  iprup_geom #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT),
    .MAX_SCALE (MAX_SCALE)
  ) u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .geom_o    (geom)
  );

  iprup_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .geom_i    (geom),
    .job_wr_o  (job_wr),
    .job_o     (job_in),
    .job_full_i(job_full)
  );

  iprup_fifo #(
    .T    (job_t),
    .DEPTH(2)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (job_wr),
    .wdata_i(job_in),
    .full_o (job_full),
    .rd_i   (job_rd),
    .rdata_o(job_out),
    .empty_o(job_empty)
  );

  iprup_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_out),
    .job_rd_o   (job_rd),
    .pitch_i    (geom.pitch),
    .out_wr_o   (out_wr),
    .out_item_o (out_in),
    .out_full_i (out_full)
  );

  iprup_fifo #(
    .T    (out_item_t),
    .DEPTH(2)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (out_wr),
    .wdata_i(out_in),
    .full_o (out_full),
    .rd_i   (pop && !empty),
    .rdata_o(out_item_o),
    .empty_o(empty)
  );

endmodule
